[rtl/bpc_pkg.sv]
// ---------------------------------------------------------------------------
// bpc_pkg
// Shared constants, types and rounding helpers for the disc pair resolver.
// ---------------------------------------------------------------------------
package bpc_pkg;

  localparam int UNIT_BITS = 30;
  localparam int REST_BITS = 16;

  localparam int RAD_W     = 27;
  localparam int REST_W    = 17;
  localparam int CFG_W     = 27;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_REST   = 2'd1;

  localparam logic [RAD_W-1:0]  RAD_RESET  = 27'd655360;
  localparam logic [REST_W-1:0] REST_RESET = 17'd58982;

  localparam int MAG_W     = RAD_W + 1;
  localparam int SQ_W      = 2 * (MAG_W + 1);
  localparam int SQ_STAGES = SQ_W / 2;
  localparam int LEN_W     = SQ_STAGES;
  localparam int NUM_W     = MAG_W + UNIT_BITS + 1;
  localparam int Q_W       = UNIT_BITS + 1;
  localparam int U_W       = Q_W + 1;

  localparam int S_W   = 35;
  localparam int PRJ_W = 65;
  localparam int CMP_W = 67;
  localparam int OFF_W = 60;
  localparam int RST_W = 53;
  localparam int SAT_W = 38;

  localparam logic signed [SAT_W-1:0] SAT_MAX = 38'sd2147483647;
  localparam logic signed [SAT_W-1:0] SAT_MIN = -38'sd2147483648;

  typedef struct packed {
    logic signed [31:0] p1x;
    logic signed [31:0] p1y;
    logic signed [31:0] v1x;
    logic signed [31:0] v1y;
    logic signed [31:0] p2x;
    logic signed [31:0] p2y;
    logic signed [31:0] v2x;
    logic signed [31:0] v2y;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [MAG_W-1:0]   adx;
    logic [MAG_W-1:0]   ady;
    logic               hit;
  } pair_t;

  typedef struct packed {
    logic               contact;
    logic signed [31:0] p1x;
    logic signed [31:0] p1y;
    logic signed [31:0] v1x;
    logic signed [31:0] v1y;
    logic signed [31:0] p2x;
    logic signed [31:0] p2y;
    logic signed [31:0] v2x;
    logic signed [31:0] v2y;
  } res_t;

  function automatic logic signed [S_W-1:0] rnd_prj(input logic signed [PRJ_W-1:0] x);
    logic signed [PRJ_W-1:0] t;
    t = x + (PRJ_W'(1) <<< (UNIT_BITS - 1));
    return t[UNIT_BITS+S_W-1:UNIT_BITS];
  endfunction

  function automatic logic signed [S_W-1:0] rnd_cmp(input logic signed [CMP_W-1:0] x);
    logic signed [CMP_W-1:0] t;
    t = x + (CMP_W'(1) <<< (UNIT_BITS - 1));
    return t[UNIT_BITS+S_W-1:UNIT_BITS];
  endfunction

  function automatic logic signed [OFF_W-UNIT_BITS-1:0] rnd_off(
    input logic signed [OFF_W-1:0] x);
    logic signed [OFF_W-1:0] t;
    t = x + (OFF_W'(1) <<< (UNIT_BITS - 1));
    return t[OFF_W-1:UNIT_BITS];
  endfunction

  function automatic logic signed [RST_W-REST_BITS-1:0] rnd_rest(
    input logic signed [RST_W-1:0] x);
    logic signed [RST_W-1:0] t;
    t = x + (RST_W'(1) <<< (REST_BITS - 1));
    return t[RST_W-1:REST_BITS];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) begin
      r = SAT_MAX[31:0];
    end else if (x < SAT_MIN) begin
      r = SAT_MIN[31:0];
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/bpc_pair_if.sv]
// ---------------------------------------------------------------------------
// bpc_pair_if
// Input channel: one disc pair word with valid/ready.
// ---------------------------------------------------------------------------
interface bpc_pair_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_pos_x;
  logic signed [31:0] first_pos_y;
  logic signed [31:0] first_vel_x;
  logic signed [31:0] first_vel_y;
  logic signed [31:0] second_pos_x;
  logic signed [31:0] second_pos_y;
  logic signed [31:0] second_vel_x;
  logic signed [31:0] second_vel_y;

  modport source (
    output valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y,
           second_pos_x, second_pos_y, second_vel_x, second_vel_y,
    input  ready
  );
  modport sink (
    input  valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y,
           second_pos_x, second_pos_y, second_vel_x, second_vel_y,
    output ready
  );
endinterface

[rtl/bpc_res_if.sv]
// ---------------------------------------------------------------------------
// bpc_res_if
// Output channel: one resolved pair word with valid/ready.
// ---------------------------------------------------------------------------
interface bpc_res_if;
  logic               valid;
  logic               ready;
  logic               contact;
  logic signed [31:0] out_first_pos_x;
  logic signed [31:0] out_first_pos_y;
  logic signed [31:0] out_first_vel_x;
  logic signed [31:0] out_first_vel_y;
  logic signed [31:0] out_second_pos_x;
  logic signed [31:0] out_second_pos_y;
  logic signed [31:0] out_second_vel_x;
  logic signed [31:0] out_second_vel_y;

  modport source (
    output valid, contact, out_first_pos_x, out_first_pos_y, out_first_vel_x,
           out_first_vel_y, out_second_pos_x, out_second_pos_y,
           out_second_vel_x, out_second_vel_y,
    input  ready
  );
  modport sink (
    input  valid, contact, out_first_pos_x, out_first_pos_y, out_first_vel_x,
           out_first_vel_y, out_second_pos_x, out_second_pos_y,
           out_second_vel_x, out_second_vel_y,
    output ready
  );
endinterface

[rtl/bpc_sqrt.sv]
// ---------------------------------------------------------------------------
// bpc_sqrt
// Pipelined integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
module bpc_sqrt import bpc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [SQ_W-1:0]  rad_i,
  input  pair_t            pair_i,
  output logic             valid_o,
  output logic [LEN_W-1:0] len_o,
  output pair_t            pair_o
);

  logic [SQ_W-1:0] v_q [SQ_STAGES];
  logic [SQ_W-1:0] r_q [SQ_STAGES];
  pair_t           p_q [SQ_STAGES];
  logic            vld_q [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    localparam logic [SQ_W-1:0] BitK = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    logic [SQ_W-1:0] v_in;
    logic [SQ_W-1:0] r_in;
    logic [SQ_W-1:0] trial;
    pair_t           p_in;
    logic            vld_in;

    if (k == 0) begin : g_first
      assign v_in   = rad_i;
      assign r_in   = '0;
      assign p_in   = pair_i;
      assign vld_in = valid_i;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign r_in   = r_q[k-1];
      assign p_in   = p_q[k-1];
      assign vld_in = vld_q[k-1];
    end

    assign trial = r_in + BitK;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v_in >= trial) begin
          v_q[k] <= v_in - trial;
          r_q[k] <= (r_in >> 1) + BitK;
        end else begin
          v_q[k] <= v_in;
          r_q[k] <= r_in >> 1;
        end
        p_q[k] <= p_in;
      end
    end
  end

  assign valid_o = vld_q[SQ_STAGES-1];
  assign len_o   = r_q[SQ_STAGES-1][LEN_W-1:0];
  assign pair_o  = p_q[SQ_STAGES-1];

endmodule

[rtl/bpc_unit.sv]
// ---------------------------------------------------------------------------
// bpc_unit
// Offset normalisation: rounded restoring division of |dx|, |dy| by length,
// one quotient bit per stage for both axes, then sign applied (zero for zero length).
// ---------------------------------------------------------------------------
module bpc_unit import bpc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [LEN_W-1:0]      len_i,
  input  pair_t                 pair_i,
  output logic                  valid_o,
  output logic signed [U_W-1:0] ux_o,
  output logic signed [U_W-1:0] uy_o,
  output pair_t                 pair_o
);

  logic [NUM_W-1:0] nx_q  [Q_W+1];
  logic [NUM_W-1:0] ny_q  [Q_W+1];
  logic [LEN_W-1:0] rx_q  [Q_W+1];
  logic [LEN_W-1:0] ry_q  [Q_W+1];
  logic [Q_W-1:0]   qx_q  [Q_W+1];
  logic [Q_W-1:0]   qy_q  [Q_W+1];
  logic [LEN_W-1:0] len_q [Q_W+1];
  logic             zero_q [Q_W+1];
  pair_t            p_q   [Q_W+1];
  logic             vld_q [Q_W+1];

  logic [NUM_W-1:0] nx_d;
  logic [NUM_W-1:0] ny_d;

  // numerator with half-divisor rounding term
  assign nx_d = {1'b0, pair_i.adx, {UNIT_BITS{1'b0}}} + NUM_W'(len_i >> 1);
  assign ny_d = {1'b0, pair_i.ady, {UNIT_BITS{1'b0}}} + NUM_W'(len_i >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q[0]   <= nx_d;
      ny_q[0]   <= ny_d;
      rx_q[0]   <= LEN_W'(nx_d[NUM_W-1:Q_W]);
      ry_q[0]   <= LEN_W'(ny_d[NUM_W-1:Q_W]);
      qx_q[0]   <= '0;
      qy_q[0]   <= '0;
      len_q[0]  <= len_i;
      zero_q[0] <= (len_i == '0);
      p_q[0]    <= pair_i;
    end
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    localparam int Bit = Q_W - 1 - j;
    logic [LEN_W:0] tx;
    logic [LEN_W:0] ty;
    logic [LEN_W:0] dv;
    logic           gx;
    logic           gy;

    assign tx = {rx_q[j], nx_q[j][Bit]};
    assign ty = {ry_q[j], ny_q[j][Bit]};
    assign dv = {1'b0, len_q[j]};
    assign gx = (tx >= dv);
    assign gy = (ty >= dv);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[j+1]   <= gx ? LEN_W'(tx - dv) : tx[LEN_W-1:0];
        ry_q[j+1]   <= gy ? LEN_W'(ty - dv) : ty[LEN_W-1:0];
        qx_q[j+1]   <= {qx_q[j][Q_W-2:0], gx};
        qy_q[j+1]   <= {qy_q[j][Q_W-2:0], gy};
        nx_q[j+1]   <= nx_q[j];
        ny_q[j+1]   <= ny_q[j];
        len_q[j+1]  <= len_q[j];
        zero_q[j+1] <= zero_q[j];
        p_q[j+1]    <= p_q[j];
      end
    end
  end

  logic                  vo_q;
  logic signed [U_W-1:0] ux_q;
  logic signed [U_W-1:0] uy_q;
  pair_t                 po_q;
  logic signed [U_W-1:0] mx;
  logic signed [U_W-1:0] my;

  assign mx = $signed({1'b0, qx_q[Q_W]});
  assign my = $signed({1'b0, qy_q[Q_W]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= vld_q[Q_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (zero_q[Q_W]) begin
        ux_q <= '0;
        uy_q <= '0;
      end else begin
        ux_q <= p_q[Q_W].dx[32] ? -mx : mx;
        uy_q <= p_q[Q_W].dy[32] ? -my : my;
      end
      po_q <= p_q[Q_W];
    end
  end

  assign valid_o = vo_q;
  assign ux_o    = ux_q;
  assign uy_o    = uy_q;
  assign pair_o  = po_q;

endmodule

[rtl/bpc_resolve.sv]
// ---------------------------------------------------------------------------
// bpc_resolve
// Projection, approach test, normal exchange with restitution and
// separation about the midpoint; five register stages, the last one drives
// the output word.
// ---------------------------------------------------------------------------
module bpc_resolve import bpc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic signed [U_W-1:0] ux_i,
  input  logic signed [U_W-1:0] uy_i,
  input  pair_t                 pair_i,
  input  logic [RAD_W-1:0]      radius_i,
  input  logic [REST_W-1:0]     restitution_i,
  output logic                  valid_o,
  output res_t                  res_o
);

  logic [4:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  // stage 1: velocity by unit products, offset products, midpoint
  logic signed [PRJ_W-2:0] a1xx_q, a1yy_q, a1xy_q, a1yx_q;
  logic signed [PRJ_W-2:0] a2xx_q, a2yy_q, a2xy_q, a2yx_q;
  logic signed [OFF_W-1:0] ox_q, oy_q;
  logic signed [33:0]      mx_q, my_q;
  logic signed [U_W-1:0]   ux1_q, uy1_q, nux1_q;
  pair_t                   p1_q;
  logic signed [RAD_W:0]   rs;

  assign rs = $signed({1'b0, radius_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1xx_q <= pair_i.v1x * ux_i;
      a1yy_q <= pair_i.v1y * uy_i;
      a1xy_q <= pair_i.v1x * uy_i;
      a1yx_q <= pair_i.v1y * ux_i;
      a2xx_q <= pair_i.v2x * ux_i;
      a2yy_q <= pair_i.v2y * uy_i;
      a2xy_q <= pair_i.v2x * uy_i;
      a2yx_q <= pair_i.v2y * ux_i;
      ox_q   <= ux_i * rs;
      oy_q   <= uy_i * rs;
      mx_q   <= pair_i.p1x + (pair_i.dx >>> 1);
      my_q   <= pair_i.p1y + (pair_i.dy >>> 1);
      ux1_q  <= ux_i;
      uy1_q  <= uy_i;
      nux1_q <= -ux_i;
      p1_q   <= pair_i;
    end
  end

  // stage 2: scalar projections, separated positions
  logic signed [S_W-1:0]   sn1_q, st1_q, sn2_q, st2_q;
  logic signed [31:0]      q1x_q, q1y_q, q2x_q, q2y_q;
  logic signed [U_W-1:0]   ux2_q, uy2_q, nux2_q;
  pair_t                   p2_q;
  logic signed [PRJ_W-1:0] sn1_d, st1_d, sn2_d, st2_d;
  logic signed [OFF_W-UNIT_BITS-1:0] ox_r, oy_r;
  logic signed [34:0]      d1x, d1y, d2x, d2y;

  always_comb begin
    sn1_d = a1xx_q + a1yy_q;
    st1_d = a1xy_q - a1yx_q;
    sn2_d = a2xx_q + a2yy_q;
    st2_d = a2xy_q - a2yx_q;
    ox_r  = rnd_off(ox_q);
    oy_r  = rnd_off(oy_q);
    d1x   = mx_q - ox_r;
    d1y   = my_q - oy_r;
    d2x   = mx_q + ox_r;
    d2y   = my_q + oy_r;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sn1_q  <= rnd_prj(sn1_d);
      st1_q  <= rnd_prj(st1_d);
      sn2_q  <= rnd_prj(sn2_d);
      st2_q  <= rnd_prj(st2_d);
      q1x_q  <= sat32({{3{d1x[34]}}, d1x});
      q1y_q  <= sat32({{3{d1y[34]}}, d1y});
      q2x_q  <= sat32({{3{d2x[34]}}, d2x});
      q2y_q  <= sat32({{3{d2y[34]}}, d2y});
      ux2_q  <= ux1_q;
      uy2_q  <= uy1_q;
      nux2_q <= nux1_q;
      p2_q   <= p1_q;
    end
  end

  // stage 3: component vectors
  logic signed [S_W-1:0]   n1x_q, n1y_q, n2x_q, n2y_q;
  logic signed [S_W-1:0]   t1x_q, t1y_q, t2x_q, t2y_q;
  logic signed [31:0]      q1x3_q, q1y3_q, q2x3_q, q2y3_q;
  pair_t                   p3_q;
  logic signed [CMP_W-1:0] c_n1x, c_n1y, c_n2x, c_n2y;
  logic signed [CMP_W-1:0] c_t1x, c_t1y, c_t2x, c_t2y;

  always_comb begin
    c_n1x = ux2_q * sn1_q;
    c_n1y = uy2_q * sn1_q;
    c_n2x = ux2_q * sn2_q;
    c_n2y = uy2_q * sn2_q;
    c_t1x = uy2_q * st1_q;
    c_t1y = nux2_q * st1_q;
    c_t2x = uy2_q * st2_q;
    c_t2y = nux2_q * st2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n1x_q  <= rnd_cmp(c_n1x);
      n1y_q  <= rnd_cmp(c_n1y);
      n2x_q  <= rnd_cmp(c_n2x);
      n2y_q  <= rnd_cmp(c_n2y);
      t1x_q  <= rnd_cmp(c_t1x);
      t1y_q  <= rnd_cmp(c_t1y);
      t2x_q  <= rnd_cmp(c_t2x);
      t2y_q  <= rnd_cmp(c_t2y);
      q1x3_q <= q1x_q;
      q1y3_q <= q1y_q;
      q2x3_q <= q2x_q;
      q2y3_q <= q2y_q;
      p3_q   <= p2_q;
    end
  end

  // stage 4: approach products, exchanged velocities, normal ordering
  logic signed [67:0]      f1x_q, f1y_q, f2x_q, f2y_q;
  logic signed [31:0]      e1x_q, e1y_q, e2x_q, e2y_q;
  logic                    gt1_q, gt2_q;
  logic signed [31:0]      q1x4_q, q1y4_q, q2x4_q, q2y4_q;
  pair_t                   p4_q;
  logic signed [REST_W:0]  es;
  logic signed [RST_W-1:0] m1x, m1y, m2x, m2y;
  logic signed [SAT_W-1:0] w1x, w1y, w2x, w2y;

  assign es = $signed({1'b0, restitution_i});

  always_comb begin
    m1x = es * n2x_q;
    m1y = es * n2y_q;
    m2x = es * n1x_q;
    m2y = es * n1y_q;
    w1x = rnd_rest(m1x) + t1x_q;
    w1y = rnd_rest(m1y) + t1y_q;
    w2x = rnd_rest(m2x) + t2x_q;
    w2y = rnd_rest(m2y) + t2y_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1x_q  <= n1x_q * p3_q.dx;
      f1y_q  <= n1y_q * p3_q.dy;
      f2x_q  <= n2x_q * p3_q.dx;
      f2y_q  <= n2y_q * p3_q.dy;
      e1x_q  <= sat32(w1x);
      e1y_q  <= sat32(w1y);
      e2x_q  <= sat32(w2x);
      e2y_q  <= sat32(w2y);
      gt1_q  <= (n1x_q > n2x_q) || (n1y_q > n2y_q);
      gt2_q  <= (n2x_q > n1x_q) || (n2y_q > n1y_q);
      q1x4_q <= q1x3_q;
      q1y4_q <= q1y3_q;
      q2x4_q <= q2x3_q;
      q2y4_q <= q2y3_q;
      p4_q   <= p3_q;
    end
  end

  // stage 5: approach decision and output word
  res_t               res_q;
  logic signed [68:0] g1;
  logic signed [68:0] g2;
  logic               f1;
  logic               f2;
  logic               xchg;

  always_comb begin
    g1   = f1x_q + f1y_q;
    g2   = f2x_q + f2y_q;
    f1   = (g1 > 69'sd0);
    f2   = (g2 < 69'sd0);
    xchg = p4_q.hit && ((f1 && f2) || (f1 && gt1_q) || (f2 && gt2_q));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.contact <= p4_q.hit;
      res_q.p1x     <= p4_q.hit ? q1x4_q : p4_q.p1x;
      res_q.p1y     <= p4_q.hit ? q1y4_q : p4_q.p1y;
      res_q.p2x     <= p4_q.hit ? q2x4_q : p4_q.p2x;
      res_q.p2y     <= p4_q.hit ? q2y4_q : p4_q.p2y;
      res_q.v1x     <= xchg ? e1x_q : p4_q.v1x;
      res_q.v1y     <= xchg ? e1y_q : p4_q.v1y;
      res_q.v2x     <= xchg ? e2x_q : p4_q.v2x;
      res_q.v2y     <= xchg ? e2y_q : p4_q.v2y;
    end
  end

  assign valid_o = vld_q[4];
  assign res_o   = res_q;

endmodule

[rtl/ball_pair_collision_resolve_unit.sv]
// ---------------------------------------------------------------------------
// ball_pair_collision_resolve_unit
// Made of 4 contact-test stages, 29 square-root stages, 33 normalisation
// stages (input, one per quotient bit, sign) and 5 resolve stages.
// Throughput one pair word per cycle; the whole pipeline holds while the
// output word waits. Reset clears valid bits and loads the register defaults.
// ---------------------------------------------------------------------------
module ball_pair_collision_resolve_unit import bpc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  bpc_pair_if.sink             pair_i,
  bpc_res_if.source            res_o
);

  logic [RAD_W-1:0]    radius_q;
  logic [REST_W-1:0]   rest_q;
  logic [2*MAG_W-1:0]  diam_sq_q;
  logic [MAG_W-1:0]    diam;
  logic                pipe_en;
  logic                out_valid;

  assign diam = {radius_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RAD_RESET;
      rest_q   <= REST_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_RADIUS: radius_q <= cfg_data_i[RAD_W-1:0];
        CFG_IDX_REST:   rest_q   <= cfg_data_i[REST_W-1:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    diam_sq_q <= diam * diam;
  end

  assign pipe_en      = !out_valid || res_o.ready;
  assign pair_i.ready = pipe_en;

  // front end: offset, range check, squares, contact
  logic [3:0]        fv_q;
  pair_t             f1_q, f2_q, f3_q, f4_q;
  logic              inr2_q, inr3_q;
  logic [2*MAG_W-1:0] sqx_q, sqy_q;
  logic [SQ_W-1:0]   d2_q;
  logic [32:0]       adx_w, ady_w;
  pair_t             in_w;
  pair_t             f2_w;
  pair_t             f4_w;

  always_comb begin
    in_w     = '0;
    in_w.p1x = pair_i.first_pos_x;
    in_w.p1y = pair_i.first_pos_y;
    in_w.v1x = pair_i.first_vel_x;
    in_w.v1y = pair_i.first_vel_y;
    in_w.p2x = pair_i.second_pos_x;
    in_w.p2y = pair_i.second_pos_y;
    in_w.v2x = pair_i.second_vel_x;
    in_w.v2y = pair_i.second_vel_y;
    in_w.dx  = pair_i.second_pos_x - pair_i.first_pos_x;
    in_w.dy  = pair_i.second_pos_y - pair_i.first_pos_y;
    adx_w    = f1_q.dx[32] ? 33'(-f1_q.dx) : 33'(f1_q.dx);
    ady_w    = f1_q.dy[32] ? 33'(-f1_q.dy) : 33'(f1_q.dy);
    f2_w     = f1_q;
    f2_w.adx = adx_w[MAG_W-1:0];
    f2_w.ady = ady_w[MAG_W-1:0];
  end

  always_comb begin
    f4_w     = f3_q;
    f4_w.hit = inr3_q && ((SQ_W'(sqx_q) + SQ_W'(sqy_q)) <= SQ_W'(diam_sq_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else if (pipe_en) begin
      fv_q <= {fv_q[2:0], pair_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      f1_q       <= in_w;
      f2_q       <= f2_w;
      inr2_q     <= (adx_w <= 33'(diam)) && (ady_w <= 33'(diam));
      f3_q       <= f2_q;
      inr3_q     <= inr2_q;
      sqx_q      <= f2_q.adx * f2_q.adx;
      sqy_q      <= f2_q.ady * f2_q.ady;
      f4_q       <= f4_w;
      d2_q       <= SQ_W'(sqx_q) + SQ_W'(sqy_q);
    end
  end

  logic             s_valid;
  logic [LEN_W-1:0] s_len;
  pair_t            s_pair;

  bpc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (fv_q[3]),
    .rad_i   (d2_q),
    .pair_i  (f4_q),
    .valid_o (s_valid),
    .len_o   (s_len),
    .pair_o  (s_pair)
  );

  logic                  u_valid;
  logic signed [U_W-1:0] u_ux;
  logic signed [U_W-1:0] u_uy;
  pair_t                 u_pair;

  bpc_unit u_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s_valid),
    .len_i   (s_len),
    .pair_i  (s_pair),
    .valid_o (u_valid),
    .ux_o    (u_ux),
    .uy_o    (u_uy),
    .pair_o  (u_pair)
  );

  res_t res_w;

  bpc_resolve u_resolve (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (pipe_en),
    .valid_i       (u_valid),
    .ux_i          (u_ux),
    .uy_i          (u_uy),
    .pair_i        (u_pair),
    .radius_i      (radius_q),
    .restitution_i (rest_q),
    .valid_o       (out_valid),
    .res_o         (res_w)
  );

  assign res_o.valid            = out_valid;
  assign res_o.contact          = res_w.contact;
  assign res_o.out_first_pos_x  = res_w.p1x;
  assign res_o.out_first_pos_y  = res_w.p1y;
  assign res_o.out_first_vel_x  = res_w.v1x;
  assign res_o.out_first_vel_y  = res_w.v1y;
  assign res_o.out_second_pos_x = res_w.p2x;
  assign res_o.out_second_pos_y = res_w.p2y;
  assign res_o.out_second_vel_x = res_w.v2x;
  assign res_o.out_second_vel_y = res_w.v2y;

`ifndef SYNTH
  localparam logic signed [U_W-1:0] UnitOne = U_W'(1) <<< UNIT_BITS;

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !res_o.ready) |-> !pair_i.ready)
    else $error("input taken while output word stalled");

  a_unit_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (u_valid && u_pair.hit) |->
      (u_ux <= UnitOne && u_ux >= -UnitOne && u_uy <= UnitOne && u_uy >= -UnitOne))
    else $error("unit vector component out of range");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(out_valid) && $stable(res_w))
    else $error("output word changed during stall");
`endif

endmodule
